>>> design/first_fit_segment_allocator_assert.svh
// Assertion macros for the first-fit segment allocator.
// Used by the top level only; no dependencies.
`ifndef FIRST_FIT_SEGMENT_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_SEGMENT_ALLOCATOR_ASSERT_SVH

// a implies b on the next cycle
`define FFSA_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");

// a implies b on the same cycle
`define FFSA_ASSERT_SAME(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");

`endif

>>> design/ffsa_pkg.sv
// Shared constants, types, command enum and status struct of the segment allocator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ffsa_pkg;
  localparam int MemWords = 128;
  localparam int MaxSegs = 16;
  localparam int WordBits = 32;
  localparam int AddrW = $clog2(MemWords);
  localparam int CntW = $clog2(MemWords + 1);
  localparam int SlotW = $clog2(MaxSegs);
  localparam int LinkW = $clog2(MaxSegs + 1);
  localparam int StepW = $clog2(MaxSegs + 1);
  localparam logic [LinkW-1:0] Nil = LinkW'(MaxSegs);

  typedef logic [AddrW-1:0] addr_t;
  typedef logic [CntW-1:0] cnt_t;
  typedef logic [LinkW-1:0] link_t;
  typedef logic [WordBits-1:0] word_t;

  localparam logic [1:0] KindCreate = 2'd0;
  localparam logic [1:0] KindDelete = 2'd1;
  localparam logic [1:0] KindWrite = 2'd2;
  localparam logic [1:0] KindRead = 2'd3;

  localparam logic [2:0] StOk = 3'd0;
  localparam logic [2:0] StNoMem = 3'd1;
  localparam logic [2:0] StNoSlot = 3'd2;
  localparam logic [2:0] StBadHandle = 3'd3;
  localparam logic [2:0] StBadPos = 3'd4;
  localparam logic [2:0] StBadSize = 3'd5;

  typedef enum logic [3:0] {
    CmdNone, CmdLatch, CmdSearchInit, CmdSearchStep, CmdPlace,
    CmdCompInit, CmdCompSeg, CmdCompRead, CmdCompMove, CmdCompNext, CmdUnlinkInit,
    CmdUnlinkStep, CmdUnlinkDo, CmdMemWrite, CmdMemRead
  } cmd_t;

  typedef struct packed {
    logic fit;          // current gap holds request
    logic walk_end;     // no more descriptors to walk
    logic slot_found;
    logic size_zero;
    logic handle_bad;
    logic pos_bad;
    logic comp_end;     // compaction list exhausted
    logic move_end;     // current segment moved
    logic unlink_hit;   // walker reached target or end
  } stat_t;
endpackage
`default_nettype wire

>>> design/ffsa_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module ffsa_ram #(
  parameter int Width = 32,
  parameter int Depth = 128
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire  [$clog2(Depth)-1:0] addr,
  input  wire  [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

>>> design/ffsa_datapath.sv
// Datapath: descriptor table, list walkers, word memory and result fields.
// Depends on ffsa_pkg and ffsa_ram.
`timescale 1ns / 1ps
`default_nettype none
module ffsa_datapath (
  input  wire                           clk,
  input  wire                           rst_n,
  input  ffsa_pkg::cmd_t                cmd,
  input  wire  [1:0]                    in_kind,
  input  wire  [7:0]                    in_req_size,
  input  wire  [3:0]                    in_handle,
  input  wire  [7:0]                    in_position,
  input  wire  signed [31:0]            in_write_value,
  output ffsa_pkg::stat_t               stat,
  output logic [ffsa_pkg::SlotW-1:0]    slot,
  output logic [1:0]                    kind,
  output logic signed [31:0]            rd_word
);
  localparam int SlotW = ffsa_pkg::SlotW;
  localparam int MaxSegs = ffsa_pkg::MaxSegs;

  ffsa_pkg::cnt_t  base_r [MaxSegs];
  ffsa_pkg::cnt_t  len_r [MaxSegs];
  ffsa_pkg::link_t link_r [MaxSegs];
  logic [MaxSegs-1:0] live_r;
  ffsa_pkg::link_t head_r;

  logic [1:0] kind_r;
  logic [7:0] size_r, pos_r;
  logic [3:0] handle_r;
  ffsa_pkg::word_t wval_r;
  logic [SlotW-1:0] slot_r;

  // walker
  ffsa_pkg::link_t prev_r, cur_r;
  logic [ffsa_pkg::CntW:0] end_r;
  logic [ffsa_pkg::StepW-1:0] steps_r;
  // compaction mover
  ffsa_pkg::cnt_t pos_c_r, src_r, i_r;

  logic [SlotW-1:0] cur_i, prev_i, h_i;
  assign cur_i = cur_r[SlotW-1:0];
  assign prev_i = prev_r[SlotW-1:0];
  assign h_i = handle_r[SlotW-1:0];

  // lowest free slot
  logic slot_found;
  logic [SlotW-1:0] free_slot;
  always_comb begin
    slot_found = 1'b0;
    free_slot = '0;
    for (int k = MaxSegs - 1; k >= 0; k--) begin
      if (!live_r[k]) begin
        slot_found = 1'b1;
        free_slot = SlotW'(k);
      end
    end
  end

  logic cur_valid;
  logic [ffsa_pkg::CntW:0] limit;
  assign cur_valid = cur_r < ffsa_pkg::Nil;
  assign limit = cur_valid ? {1'b0, base_r[cur_i]} : (ffsa_pkg::CntW+1)'(ffsa_pkg::MemWords);

  logic handle_bad;
  assign handle_bad = (32'(handle_r) >= MaxSegs) || !live_r[h_i];

  logic [8:0] addr_full;
  assign addr_full = 9'(base_r[h_i]) + 9'(pos_r) - 9'd1;

  // memory port: compaction alternates a source read and a destination write
  logic mem_we;
  ffsa_pkg::addr_t mem_addr;
  ffsa_pkg::word_t mem_wdata, mem_rdata;
  logic [ffsa_pkg::CntW:0] dst_a, src_a;
  assign dst_a = {1'b0, pos_c_r} + {1'b0, i_r};
  assign src_a = {1'b0, src_r} + {1'b0, i_r};

  always_comb begin
    mem_we = 1'b0;
    mem_addr = ffsa_pkg::AddrW'(addr_full);
    mem_wdata = wval_r;
    unique case (cmd)
      ffsa_pkg::CmdCompRead: mem_addr = ffsa_pkg::AddrW'(src_a);
      ffsa_pkg::CmdCompMove: begin
        mem_addr = ffsa_pkg::AddrW'(dst_a);
        mem_wdata = mem_rdata;
        mem_we = (dst_a < ffsa_pkg::MemWords) && (src_a < ffsa_pkg::MemWords)
                 && (i_r < len_r[cur_i]);
      end
      ffsa_pkg::CmdMemWrite: mem_we = addr_full < 9'(ffsa_pkg::MemWords);
      default: ;
    endcase
  end

  ffsa_ram #(.Width(ffsa_pkg::WordBits), .Depth(ffsa_pkg::MemWords)) u_ram (
    .clk(clk), .we(mem_we), .addr(mem_addr), .wdata(mem_wdata), .rdata(mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= '0;
      head_r <= ffsa_pkg::Nil;
      for (int k = 0; k < MaxSegs; k++) begin
        base_r[k] <= '0;
        len_r[k] <= '0;
        link_r[k] <= '0;
      end
    end else begin
      unique case (cmd)
        ffsa_pkg::CmdLatch: begin
          kind_r <= in_kind;
          size_r <= in_req_size;
          handle_r <= in_handle;
          pos_r <= in_position;
          wval_r <= in_write_value;
        end
        ffsa_pkg::CmdSearchInit: begin
          slot_r <= free_slot;
          prev_r <= ffsa_pkg::Nil;
          cur_r <= head_r;
          end_r <= '0;
          steps_r <= '0;
        end
        ffsa_pkg::CmdSearchStep: begin
          end_r <= {1'b0, base_r[cur_i]} + {1'b0, len_r[cur_i]};
          prev_r <= cur_r;
          cur_r <= link_r[cur_i];
          steps_r <= steps_r + 1'b1;
        end
        ffsa_pkg::CmdPlace: begin
          base_r[slot_r] <= ffsa_pkg::CntW'(end_r);
          len_r[slot_r] <= ffsa_pkg::CntW'(size_r);
          link_r[slot_r] <= cur_r;
          live_r[slot_r] <= 1'b1;
          if (prev_r < ffsa_pkg::Nil) begin
            link_r[prev_i] <= ffsa_pkg::LinkW'(slot_r);
          end else begin
            head_r <= ffsa_pkg::LinkW'(slot_r);
          end
        end
        ffsa_pkg::CmdCompInit: begin
          cur_r <= head_r;
          pos_c_r <= '0;
          steps_r <= '0;
        end
        ffsa_pkg::CmdCompSeg: begin
          src_r <= base_r[cur_i];
          i_r <= '0;
        end
        ffsa_pkg::CmdCompMove: i_r <= i_r + 1'b1;
        ffsa_pkg::CmdCompNext: begin
          base_r[cur_i] <= pos_c_r;
          pos_c_r <= pos_c_r + len_r[cur_i];
          cur_r <= link_r[cur_i];
          steps_r <= steps_r + 1'b1;
        end
        ffsa_pkg::CmdUnlinkInit: begin
          prev_r <= ffsa_pkg::Nil;
          cur_r <= head_r;
          steps_r <= '0;
        end
        ffsa_pkg::CmdUnlinkStep: begin
          prev_r <= cur_r;
          cur_r <= link_r[cur_i];
          steps_r <= steps_r + 1'b1;
        end
        ffsa_pkg::CmdUnlinkDo: begin
          if (cur_r == ffsa_pkg::LinkW'(handle_r)) begin
            if (prev_r < ffsa_pkg::Nil) begin
              link_r[prev_i] <= link_r[cur_i];
            end else begin
              head_r <= link_r[cur_i];
            end
          end
          live_r[h_i] <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // read word: the ram read is registered, and rd_word registers it once more
  always_ff @(posedge clk) begin
    rd_word <= (addr_full < 9'(ffsa_pkg::MemWords)) ? mem_rdata : '0;
  end

  always_comb begin
    stat.fit = (limit >= end_r) && ((limit - end_r) >= (ffsa_pkg::CntW+1)'(size_r));
    stat.walk_end = !cur_valid || (32'(steps_r) >= MaxSegs);
    stat.slot_found = slot_found;
    stat.size_zero = size_r == '0;
    stat.handle_bad = handle_bad;
    stat.pos_bad = (pos_r == '0) || (ffsa_pkg::CntW'(pos_r) > len_r[h_i]) ||
                   (9'(pos_r) > 9'(len_r[h_i]));
    stat.comp_end = !cur_valid || (32'(steps_r) >= MaxSegs);
    stat.move_end = i_r >= len_r[cur_i];
    stat.unlink_hit = !cur_valid || (cur_r == ffsa_pkg::LinkW'(handle_r)) ||
                      (32'(steps_r) >= MaxSegs);
  end

  assign slot = slot_r;
  assign kind = kind_r;
endmodule
`default_nettype wire

>>> design/ffsa_ctrl.sv
// Controller state machine: sequences requests and drives result register.
// Depends on ffsa_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ffsa_ctrl (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_valid,
  output logic                        in_stall,
  output logic                        out_valid,
  input  wire                         out_stall,
  input  ffsa_pkg::stat_t             stat,
  input  wire  [ffsa_pkg::SlotW-1:0]  slot,
  input  wire  [1:0]                  kind,
  input  wire  signed [31:0]          rd_word,
  output ffsa_pkg::cmd_t              cmd,
  output logic [2:0]                  out_status,
  output logic [3:0]                  out_new_handle,
  output logic signed [31:0]          out_read_value,
  output logic                        out_did_compact
);
  typedef enum logic [3:0] {
    SIdle, SDecode, SSearch, SPlace, SCompInit, SCompSeg, SCompRd, SCompMove,
    SCompNext, SRetry, SUnlinkInit, SUnlink, SUnlinkDo, SRead, SReadWait, SDone
  } state_t;

  state_t state_r;
  logic retry_r;

  assign in_stall = state_r != SIdle;
  // SIdle accepts when out is free; out_valid waits in SDone
  always_comb begin
    cmd = ffsa_pkg::CmdNone;
    unique case (state_r)
      SIdle: if (in_valid) cmd = ffsa_pkg::CmdLatch;
      SDecode: if (kind == ffsa_pkg::KindCreate) cmd = ffsa_pkg::CmdSearchInit;
      SSearch: begin
        if (stat.fit) cmd = ffsa_pkg::CmdPlace;
        else if (!stat.walk_end) cmd = ffsa_pkg::CmdSearchStep;
      end
      SCompInit: cmd = ffsa_pkg::CmdCompInit;
      SCompSeg: if (!stat.comp_end) cmd = ffsa_pkg::CmdCompSeg;
      SCompRd: if (!stat.move_end) cmd = ffsa_pkg::CmdCompRead;
      SCompMove: cmd = ffsa_pkg::CmdCompMove;
      SCompNext: cmd = ffsa_pkg::CmdCompNext;
      SRetry: cmd = ffsa_pkg::CmdSearchInit;
      SUnlinkInit: cmd = ffsa_pkg::CmdUnlinkInit;
      SUnlink: begin
        if (stat.unlink_hit) cmd = ffsa_pkg::CmdUnlinkDo;
        else cmd = ffsa_pkg::CmdUnlinkStep;
      end
      SRead: begin
        if (kind == ffsa_pkg::KindWrite) cmd = ffsa_pkg::CmdMemWrite;
        else cmd = ffsa_pkg::CmdMemRead;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SIdle;
      out_valid <= 1'b0;
      retry_r <= 1'b0;
    end else begin
      unique case (state_r)
        SIdle: if (in_valid) state_r <= SDecode;
        SDecode: begin
          out_status <= ffsa_pkg::StOk;
          out_new_handle <= '0;
          out_read_value <= '0;
          out_did_compact <= 1'b0;
          retry_r <= 1'b0;
          state_r <= SDone;
          if (kind == ffsa_pkg::KindCreate) begin
            if (stat.size_zero) out_status <= ffsa_pkg::StBadSize;
            else if (!stat.slot_found) out_status <= ffsa_pkg::StNoSlot;
            else state_r <= SSearch;
          end else if (stat.handle_bad) begin
            out_status <= ffsa_pkg::StBadHandle;
          end else if (kind == ffsa_pkg::KindDelete) begin
            state_r <= SUnlinkInit;
          end else if (stat.pos_bad) begin
            out_status <= ffsa_pkg::StBadPos;
          end else begin
            state_r <= SRead;
          end
        end
        SSearch: begin
          if (stat.fit) begin
            state_r <= SPlace;
          end else if (stat.walk_end) begin
            if (retry_r) begin
              out_status <= ffsa_pkg::StNoMem;
              state_r <= SDone;
            end else begin
              retry_r <= 1'b1;
              out_did_compact <= 1'b1;
              state_r <= SCompInit;
            end
          end
        end
        SPlace: begin
          out_new_handle <= 4'(slot);
          state_r <= SDone;
        end
        SCompInit: state_r <= SCompSeg;
        // list done: restart the search from the head
        SCompSeg: state_r <= stat.comp_end ? SRetry : SCompRd;
        SCompRd: state_r <= stat.move_end ? SCompNext : SCompMove;
        SCompMove: state_r <= SCompRd;
        SCompNext: state_r <= SCompSeg;
        SRetry: state_r <= SSearch;
        SUnlinkInit: state_r <= SUnlink;
        SUnlink: if (stat.unlink_hit) state_r <= SDone;
        SRead: state_r <= (kind == ffsa_pkg::KindWrite) ? SDone : SReadWait;
        SReadWait: state_r <= SDone;
        SDone: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            if (kind == ffsa_pkg::KindRead && out_status == ffsa_pkg::StOk) begin
              out_read_value <= rd_word;
            end
          end else if (!out_stall) begin
            out_valid <= 1'b0;
            state_r <= SIdle;
          end
        end
        default: state_r <= SIdle;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> design/first_fit_segment_allocator.sv
// First-fit segment allocator with compaction: top level.
// Flow: rejected requests are answered after decode; writes and reads access word
//   memory; delete walks the descriptor list; create walks up to 16 descriptors.
//   Compaction moves each segment word by word, then the create walks the list again.
// Throughput: one request at a time; the next is accepted in the cycle after result transfer.
// Reset (rst_n low, sync): descriptor table empty; word memory not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "first_fit_segment_allocator_assert.svh"
module first_fit_segment_allocator (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  wire  [1:0]          in_kind,
  input  wire  [7:0]          in_req_size,
  input  wire  [3:0]          in_handle,
  input  wire  [7:0]          in_position,
  input  wire  signed [31:0]  in_write_value,
  output logic                out_valid,
  input  wire                 out_stall,
  output logic [2:0]          out_status,
  output logic [3:0]          out_new_handle,
  output logic signed [31:0]  out_read_value,
  output logic                out_did_compact
);
  ffsa_pkg::cmd_t cmd;
  ffsa_pkg::stat_t stat;
  logic [ffsa_pkg::SlotW-1:0] slot;
  logic [1:0] kind;
  logic signed [31:0] rd_word;

  // datapath holds descriptors and memory; controller sequences each request
  ffsa_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_kind(in_kind),
    .in_req_size(in_req_size), .in_handle(in_handle), .in_position(in_position),
    .in_write_value(in_write_value), .stat(stat), .slot(slot), .kind(kind),
    .rd_word(rd_word)
  );

  ffsa_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .stat(stat), .slot(slot),
    .kind(kind), .rd_word(rd_word), .cmd(cmd), .out_status(out_status),
    .out_new_handle(out_new_handle), .out_read_value(out_read_value),
    .out_did_compact(out_did_compact)
  );

  // no new transfer in while a result is pending
  `FFSA_ASSERT_SAME(a_no_overlap, clk, rst_n, out_valid, in_stall)
  // an accepted transfer is never answered in the very next cycle
  `FFSA_ASSERT_NEXT(a_min_lat, clk, rst_n, in_valid && !in_stall, !out_valid)
  // compaction flag only for creates
  `FFSA_ASSERT_SAME(a_dc_create, clk, rst_n, out_valid && out_did_compact,
                    out_status == ffsa_pkg::StOk || out_status == ffsa_pkg::StNoMem)
endmodule
`default_nettype wire
